// ===== hw/rtl/pcq_pkg.sv =====
// Package for the per-core priority request queue.
// Holds the command and status codes, the stored entry type and the payload structs.
// No dependencies.
package pcq_pkg;

  // Command codes of an input transaction.
  typedef enum logic [1:0] {
    CMD_ENQ    = 2'd0,
    CMD_DEQ    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_CANCEL = 2'd3
  } cmd_e;

  // Status codes of a result transaction.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_NONE    = 2'd3
  } status_e;

  localparam int unsigned EntryWidth = 32;

  // One queued request as stored in the entry memory.
  typedef struct packed {
    logic [15:0] req_id;
    logic [7:0]  session;
    logic [7:0]  prio;
  } entry_t;

  // Input transaction payload.
  typedef struct packed {
    cmd_e        cmd;
    logic [2:0]  core;
    logic [15:0] req_id;
    logic [7:0]  session;
    logic [7:0]  priority_req;
  } in_data_t;

  // Result transaction payload.
  typedef struct packed {
    status_e     status;
    logic [15:0] out_req_id;
    logic [7:0]  out_session;
    logic [7:0]  out_priority;
    logic [3:0]  core_depth;
    logic [5:0]  total_depth;
    logic [5:0]  removed_count;
    logic        last;
  } out_data_t;

endpackage

// ===== hw/rtl/pcq_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds while no read is issued. No dependencies.
module pcq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/per_core_priority_request_queue_unit.sv =====
// Top level of the per-core priority request queue.
// Depends on pcq_pkg and pcq_ram.
//
// Usage: one input channel (in_valid_i/in_ready_o/in_data_i) carries commands
// (enqueue, dequeue, peek, cancel session); one output channel
// (out_valid_o/out_ready_i/out_data_o) carries results. Enqueue, dequeue and
// peek give one result; cancel gives one result per removed entry and then a
// closing result with last set. All entries live in one RAM with a registered
// read; per-core counts sit in flip-flops.
// Every entry access is a read state followed by a check or write state.
// Enqueue reads all stored entries, then shifts those behind the insertion
// point; dequeue and peek read the head, and dequeue shifts the rest up;
// cancel scans all entries twice and issues removed-entry results inside
// the second scan. One transaction is worked on at a time; the input is
// ready only when the block is idle and no result is waiting.
// Reset empties every queue at once; the RAM needs no clearing pass since
// only entries below a queue's count are ever read.
// A stalled receiver holds the result register, and the block waits at its
// next result until that register is free.
module per_core_priority_request_queue_unit #(
  parameter int unsigned CORE_COUNT  = 4,
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pcq_pkg::in_data_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pcq_pkg::out_data_t out_data_o
);
  import pcq_pkg::*;

  localparam int unsigned MemDepth = CORE_COUNT * QUEUE_DEPTH;
  localparam int unsigned AW  = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int unsigned CIW = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
  localparam int unsigned IW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ENQ_RD, S_ENQ_CHK, S_ENQ_SH_RD, S_ENQ_SH_WR, S_ENQ_INS,
    S_DEQ_RD, S_DEQ_HEAD, S_DEQ_SH_RD, S_DEQ_SH_WR,
    S_CNT_RD, S_CNT_CHK, S_CAN_RD, S_CAN_CHK, S_RESP
  } state_e;

  state_e          state_q;
  cmd_e            cmd_q;
  logic [2:0]      core_q;
  entry_t          new_q;
  logic [CIW-1:0]  c_q;
  logic [CW-1:0]   i_q, j_q, w_q, pos_q;
  logic            pos_found_q, dup_q;
  logic [5:0]      rem_q;
  logic [CW-1:0]   cnt_q      [CORE_COUNT];
  logic [CW-1:0]   scan_cnt_q [CORE_COUNT];
  status_e         res_status_q;
  entry_t          res_ent_q;
  logic            out_valid_q;
  out_data_t       out_q;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  entry_t          mem_wdata, rd_ent;
  logic [EntryWidth-1:0] rd_raw;

  logic            core_ok, out_free, out_load, c_last;
  logic [CIW-1:0]  tc;
  logic [CW-1:0]   j_dec;
  logic [3:0]      cur_core_depth;
  logic [5:0]      cur_total;

  function automatic logic [AW-1:0] mem_addr(input logic [CIW-1:0] c,
                                              input logic [IW-1:0] i);
    int a;
    a = int'(c) * QUEUE_DEPTH + int'(i);
    return a[AW-1:0];
  endfunction

  assign core_ok  = (int'(core_q) < CORE_COUNT);
  assign tc       = core_q[CIW-1:0];
  assign out_free = !out_valid_q || out_ready_i;
  assign c_last   = (int'(c_q) == CORE_COUNT - 1);
  assign j_dec    = j_q - 1'b1;
  assign rd_ent   = entry_t'(rd_raw);

  // A result is loaded when the closing result or a removed entry is ready to go.
  assign out_load = out_free && ((state_q == S_RESP) ||
                    ((state_q == S_CAN_CHK) && (rd_ent.session == new_q.session)));

  // Depth fields reported with every result, from the current counts.
  always_comb begin
    int tot;
    int cd;
    tot = 0;
    for (int c = 0; c < CORE_COUNT; c++) begin
      tot = tot + int'(cnt_q[c]);
    end
    cd = core_ok ? int'(cnt_q[tc]) : 0;
    cur_total      = tot[5:0];
    cur_core_depth = cd[3:0];
  end

  // Entry memory access control.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rd_ent;
    case (state_q)
      S_ENQ_RD: begin
        mem_re    = (i_q < cnt_q[c_q]);
        mem_raddr = mem_addr(c_q, i_q[IW-1:0]);
      end
      S_ENQ_SH_RD: begin
        mem_re    = (j_q > pos_q);
        mem_raddr = mem_addr(tc, j_dec[IW-1:0]);
      end
      S_ENQ_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = mem_addr(tc, j_q[IW-1:0]);
      end
      S_ENQ_INS: begin
        mem_we    = 1'b1;
        mem_waddr = mem_addr(tc, pos_q[IW-1:0]);
        mem_wdata = new_q;
      end
      S_DEQ_RD: begin
        mem_re    = 1'b1;
        mem_raddr = mem_addr(tc, '0);
      end
      S_DEQ_SH_RD: begin
        mem_re    = (j_q < cnt_q[tc]);
        mem_raddr = mem_addr(tc, j_q[IW-1:0]);
      end
      S_DEQ_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = mem_addr(tc, j_dec[IW-1:0]);
      end
      S_CNT_RD: begin
        mem_re    = (i_q < scan_cnt_q[c_q]);
        mem_raddr = mem_addr(c_q, i_q[IW-1:0]);
      end
      S_CAN_RD: begin
        mem_re    = (i_q < scan_cnt_q[c_q]);
        mem_raddr = mem_addr(c_q, i_q[IW-1:0]);
      end
      S_CAN_CHK: begin
        // Kept entries are compacted toward the head; w never passes i.
        mem_we    = (rd_ent.session != new_q.session);
        mem_waddr = mem_addr(c_q, w_q[IW-1:0]);
      end
      default: ;
    endcase
  end

  pcq_ram #(
    .WIDTH (EntryWidth),
    .DEPTH (MemDepth),
    .AW    (AW)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (EntryWidth'(mem_wdata)),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_raw)
  );

  // Sequencer: state, counts and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= CMD_ENQ;
      core_q       <= '0;
      new_q        <= '0;
      c_q          <= '0;
      i_q          <= '0;
      j_q          <= '0;
      w_q          <= '0;
      pos_q        <= '0;
      pos_found_q  <= 1'b0;
      dup_q        <= 1'b0;
      rem_q        <= '0;
      res_status_q <= ST_OK;
      res_ent_q    <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      for (int c = 0; c < CORE_COUNT; c++) begin
        cnt_q[c]      <= '0;
        scan_cnt_q[c] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            cmd_q        <= in_data_i.cmd;
            core_q       <= in_data_i.core;
            new_q        <= '{req_id: in_data_i.req_id, session: in_data_i.session,
                              prio: in_data_i.priority_req};
            c_q          <= '0;
            i_q          <= '0;
            w_q          <= '0;
            pos_found_q  <= 1'b0;
            dup_q        <= 1'b0;
            rem_q        <= '0;
            res_status_q <= ST_OK;
            res_ent_q    <= '0;
            case (in_data_i.cmd)
              CMD_ENQ: state_q <= S_ENQ_RD;
              CMD_DEQ, CMD_PEEK: begin
                if ((int'(in_data_i.core) >= CORE_COUNT) ||
                    (cnt_q[in_data_i.core[CIW-1:0]] == '0)) begin
                  res_status_q <= ST_NONE;
                  state_q      <= S_RESP;
                end else begin
                  state_q <= S_DEQ_RD;
                end
              end
              CMD_CANCEL: begin
                for (int c = 0; c < CORE_COUNT; c++) begin
                  scan_cnt_q[c] <= cnt_q[c];
                end
                state_q <= S_CNT_RD;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end

        // Duplicate scan over all queues, also finding the insertion point.
        S_ENQ_RD: begin
          if (i_q < cnt_q[c_q]) begin
            state_q <= S_ENQ_CHK;
          end else if (!c_last) begin
            c_q <= c_q + 1'b1;
            i_q <= '0;
          end else if (dup_q || !core_ok) begin
            res_status_q <= ST_INVALID;
            state_q      <= S_RESP;
          end else if (int'(cnt_q[tc]) >= QUEUE_DEPTH) begin
            res_status_q <= ST_FULL;
            state_q      <= S_RESP;
          end else begin
            if (!pos_found_q) begin
              pos_q <= cnt_q[tc];
            end
            j_q     <= cnt_q[tc];
            state_q <= S_ENQ_SH_RD;
          end
        end
        S_ENQ_CHK: begin
          if (rd_ent.req_id == new_q.req_id) begin
            dup_q <= 1'b1;
          end
          if (core_ok && (c_q == tc) && !pos_found_q && (rd_ent.prio < new_q.prio)) begin
            pos_q       <= i_q;
            pos_found_q <= 1'b1;
          end
          i_q     <= i_q + 1'b1;
          state_q <= S_ENQ_RD;
        end

        // Shift the tail down by one to open the insertion slot.
        S_ENQ_SH_RD: begin
          state_q <= (j_q > pos_q) ? S_ENQ_SH_WR : S_ENQ_INS;
        end
        S_ENQ_SH_WR: begin
          j_q     <= j_dec;
          state_q <= S_ENQ_SH_RD;
        end
        S_ENQ_INS: begin
          cnt_q[tc] <= cnt_q[tc] + 1'b1;
          state_q   <= S_RESP;
        end

        // Dequeue and peek read the head; dequeue then moves the rest up.
        S_DEQ_RD: state_q <= S_DEQ_HEAD;
        S_DEQ_HEAD: begin
          res_ent_q <= rd_ent;
          if (cmd_q == CMD_PEEK) begin
            state_q <= S_RESP;
          end else begin
            j_q     <= CW'(1);
            state_q <= S_DEQ_SH_RD;
          end
        end
        S_DEQ_SH_RD: begin
          if (j_q < cnt_q[tc]) begin
            state_q <= S_DEQ_SH_WR;
          end else begin
            cnt_q[tc] <= cnt_q[tc] - 1'b1;
            state_q   <= S_RESP;
          end
        end
        S_DEQ_SH_WR: begin
          j_q     <= j_q + 1'b1;
          state_q <= S_DEQ_SH_RD;
        end

        // Cancel, first pass: settle the final counts.
        S_CNT_RD: begin
          if (i_q < scan_cnt_q[c_q]) begin
            state_q <= S_CNT_CHK;
          end else if (!c_last) begin
            c_q <= c_q + 1'b1;
            i_q <= '0;
          end else begin
            c_q     <= '0;
            i_q     <= '0;
            w_q     <= '0;
            state_q <= S_CAN_RD;
          end
        end
        S_CNT_CHK: begin
          if (rd_ent.session == new_q.session) begin
            cnt_q[c_q] <= cnt_q[c_q] - 1'b1;
          end
          i_q     <= i_q + 1'b1;
          state_q <= S_CNT_RD;
        end

        // Cancel, second pass: compact each queue and report removed entries.
        S_CAN_RD: begin
          if (i_q < scan_cnt_q[c_q]) begin
            state_q <= S_CAN_CHK;
          end else if (!c_last) begin
            c_q <= c_q + 1'b1;
            i_q <= '0;
            w_q <= '0;
          end else begin
            state_q <= S_RESP;
          end
        end
        S_CAN_CHK: begin
          if (rd_ent.session != new_q.session) begin
            w_q     <= w_q + 1'b1;
            i_q     <= i_q + 1'b1;
            state_q <= S_CAN_RD;
          end else if (out_free) begin
            out_q <= '{status: ST_OK, out_req_id: rd_ent.req_id,
                       out_session: rd_ent.session, out_priority: rd_ent.prio,
                       core_depth: cur_core_depth, total_depth: cur_total,
                       removed_count: '0, last: 1'b0};
            rem_q   <= rem_q + 1'b1;
            i_q     <= i_q + 1'b1;
            state_q <= S_CAN_RD;
          end
        end

        // Closing result of the transaction.
        S_RESP: begin
          if (out_free) begin
            out_q <= '{status: res_status_q, out_req_id: res_ent_q.req_id,
                       out_session: res_ent_q.session, out_priority: res_ent_q.prio,
                       core_depth: cur_core_depth, total_depth: cur_total,
                       removed_count: rem_q, last: 1'b1};
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // No queue ever holds more than its depth.
  for (genvar g = 0; g < CORE_COUNT; g++) begin : g_cnt_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      int'(cnt_q[g]) <= QUEUE_DEPTH)
      else $error("queue count above depth");
  end

  // The memory is never written while the block is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("entry write while idle");

  // An accepted transaction deasserts input ready in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after an accept");

  // A result marked last returns the block to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && out_q.last) |-> (state_q == S_IDLE))
    else $error("closing result without return to idle");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the per-core priority request queue.
// Depends on pcq_pkg and per_core_priority_request_queue_unit.
// Drives directed and random commands, predicts every result and compares them.
module tb_top;
  import pcq_pkg::*;

  localparam int unsigned Cores = 4;
  localparam int unsigned Depth = 8;
  localparam int unsigned NumRandom = 240;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_data_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_data_t out_data;

  per_core_priority_request_queue_unit #(
    .CORE_COUNT (Cores),
    .QUEUE_DEPTH(Depth)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // Clock with a period of 10.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the queues kept by the predictor.
  entry_t      shadow_q[Cores][Depth];
  int unsigned shadow_cnt[Cores];
  out_data_t   pending_results[$];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned items_sent;
  int unsigned cancels_sent;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_recv;

  function automatic int unsigned shadow_total();
    int unsigned t;
    t = 0;
    for (int c = 0; c < Cores; c++) t += shadow_cnt[c];
    return t;
  endfunction

  // Appends one expected result at the tail of the scoreboard.
  function automatic void queue_expected(out_data_t r);
    pending_results = {pending_results, r};
  endfunction

  // Builds one result with the depths as they stand now.
  function automatic out_data_t make_result(status_e st, entry_t e, logic [2:0] core,
                                            int unsigned removed, logic last);
    out_data_t r;
    r.status        = st;
    r.out_req_id    = e.req_id;
    r.out_session   = e.session;
    r.out_priority  = e.prio;
    r.core_depth    = (core < Cores) ? 4'(shadow_cnt[core]) : 4'd0;
    r.total_depth   = 6'(shadow_total());
    r.removed_count = 6'(removed);
    r.last          = last;
    return r;
  endfunction

  // Applies one command to the shadow queues and queues the expected results.
  task automatic predict_queue_op(in_data_t d);
    entry_t      ne;
    entry_t      zero;
    entry_t      gone[$];
    bit          dup;
    int unsigned n;
    int unsigned pos;
    int unsigned w;
    zero = '0;
    ne.req_id = d.req_id;
    ne.session = d.session;
    ne.prio = d.priority_req;
    case (d.cmd)
      CMD_ENQ: begin
        dup = 1'b0;
        for (int c = 0; c < Cores; c++)
          for (int i = 0; i < shadow_cnt[c]; i++)
            if (shadow_q[c][i].req_id == d.req_id) dup = 1'b1;
        if (dup || d.core >= Cores) begin
          queue_expected(make_result(ST_INVALID, zero, d.core, 0, 1'b1));
        end else if (shadow_cnt[d.core] >= Depth) begin
          queue_expected(make_result(ST_FULL, zero, d.core, 0, 1'b1));
        end else begin
          n = shadow_cnt[d.core];
          pos = 0;
          while (pos < n && shadow_q[d.core][pos].prio >= ne.prio) pos++;
          for (int j = n; j > pos; j--) shadow_q[d.core][j] = shadow_q[d.core][j-1];
          shadow_q[d.core][pos] = ne;
          shadow_cnt[d.core] = n + 1;
          queue_expected(make_result(ST_OK, zero, d.core, 0, 1'b1));
        end
      end
      CMD_DEQ, CMD_PEEK: begin
        if (d.core >= Cores || shadow_cnt[d.core] == 0) begin
          queue_expected(make_result(ST_NONE, zero, d.core, 0, 1'b1));
        end else begin
          ne = shadow_q[d.core][0];
          if (d.cmd == CMD_DEQ) begin
            for (int j = 1; j < shadow_cnt[d.core]; j++)
              shadow_q[d.core][j-1] = shadow_q[d.core][j];
            shadow_cnt[d.core]--;
          end
          queue_expected(make_result(ST_OK, ne, d.core, 0, 1'b1));
        end
      end
      default: begin
        // Cancel: compact every queue, then report removed entries in scan order.
        for (int c = 0; c < Cores; c++) begin
          w = 0;
          for (int i = 0; i < shadow_cnt[c]; i++) begin
            if (shadow_q[c][i].session == d.session) gone = {gone, shadow_q[c][i]};
            else begin
              shadow_q[c][w] = shadow_q[c][i];
              w++;
            end
          end
          shadow_cnt[c] = w;
        end
        foreach (gone[k])
          queue_expected(make_result(ST_OK, gone[k], d.core, 0, 1'b0));
        queue_expected(make_result(ST_OK, zero, d.core, gone.size(), 1'b1));
      end
    endcase
  endtask

  // Directed rows; a row with has_exp set also carries a result typed in by hand.
  typedef struct {
    in_data_t  cmd;
    bit        has_exp;
    out_data_t exp;
  } directed_row_t;

  directed_row_t directed_rows[$];

  function automatic in_data_t mk_cmd(cmd_e c, logic [2:0] core, logic [15:0] id,
                                      logic [7:0] ses, logic [7:0] pr);
    in_data_t d;
    d.cmd = c;
    d.core = core;
    d.req_id = id;
    d.session = ses;
    d.priority_req = pr;
    return d;
  endfunction

  function automatic out_data_t mk_res(status_e st, logic [3:0] cd, logic [5:0] td);
    out_data_t r;
    r = '0;
    r.status = st;
    r.core_depth = cd;
    r.total_depth = td;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic add_row(in_data_t d);
    directed_row_t r;
    r.cmd = d;
    r.has_exp = 1'b0;
    r.exp = '0;
    directed_rows = {directed_rows, r};
  endtask

  task automatic add_row_exp(in_data_t d, out_data_t e);
    directed_row_t r;
    r.cmd = d;
    r.has_exp = 1'b1;
    r.exp = e;
    directed_rows = {directed_rows, r};
  endtask

  // Sends one transaction and waits for its acceptance; valid stays up
  // afterwards until the next call idles or replaces the payload.
  task automatic send_item(in_data_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_queue_op(d);
    items_sent++;
    if (d.cmd == CMD_CANCEL) cancels_sent++;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random command; mostly live ids and sessions so queues fill and cancels hit.
  function automatic in_data_t random_cmd();
    in_data_t    d;
    int unsigned sel;
    sel = $urandom_range(99);
    d.cmd = (sel < 50) ? CMD_ENQ : (sel < 75) ? CMD_DEQ : (sel < 88) ? CMD_PEEK
                                                        : CMD_CANCEL;
    d.core = ($urandom_range(9) == 0) ? 3'($urandom_range(7, Cores))
                                      : 3'($urandom_range(Cores - 1));
    d.req_id = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
    d.session = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    d.priority_req = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    return d;
  endfunction

  // Result checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", out_data);
      end else if (out_data !== pending_results[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result mismatch, expected %p, got %p",
                   pending_results[0], out_data);
        pending_results.delete(0);
      end else begin
        pending_results.delete(0);
      end
    end
  end

  // Receiver readiness, with a long hold-off whenever requested.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    in_data_t d;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_recv = 1'b0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    cancels_sent = 0;
    send_idle_pct = 25;
    recv_idle_pct = 63;
    for (int c = 0; c < Cores; c++) shadow_cnt[c] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty reads, bad cores, ordering, duplicates, full, cancel.
    add_row_exp(mk_cmd(CMD_DEQ, 3'd0, 16'd0, 8'd0, 8'd0), mk_res(ST_NONE, 4'd0, 6'd0));
    add_row_exp(mk_cmd(CMD_PEEK, 3'd7, 16'd0, 8'd0, 8'd0), mk_res(ST_NONE, 4'd0, 6'd0));
    add_row_exp(mk_cmd(CMD_ENQ, 3'd7, 16'hFFFF, 8'hFF, 8'hFF),
                mk_res(ST_INVALID, 4'd0, 6'd0));
    add_row_exp(mk_cmd(CMD_ENQ, 3'd0, 16'hFFFF, 8'hFF, 8'hFF), mk_res(ST_OK, 4'd1, 6'd1));
    add_row_exp(mk_cmd(CMD_ENQ, 3'd1, 16'hFFFF, 8'd1, 8'd1),
                mk_res(ST_INVALID, 4'd0, 6'd1));
    add_row(mk_cmd(CMD_ENQ, 3'd0, 16'd0, 8'd0, 8'd0));
    add_row(mk_cmd(CMD_ENQ, 3'd0, 16'd1, 8'd1, 8'hFF));
    add_row(mk_cmd(CMD_ENQ, 3'd0, 16'd2, 8'd0, 8'd7));
    add_row(mk_cmd(CMD_PEEK, 3'd0, 16'd0, 8'd0, 8'd0));
    for (int i = 0; i < 6; i++) add_row(mk_cmd(CMD_ENQ, 3'd3, 16'(16'h100 + i), 8'd1, 8'(i)));
    add_row(mk_cmd(CMD_ENQ, 3'd3, 16'h200, 8'd2, 8'd3));
    add_row(mk_cmd(CMD_ENQ, 3'd3, 16'h201, 8'd2, 8'd3));
    add_row_exp(mk_cmd(CMD_ENQ, 3'd3, 16'h202, 8'd2, 8'd3), mk_res(ST_FULL, 4'd8, 6'd12));
    add_row(mk_cmd(CMD_DEQ, 3'd0, 16'd0, 8'd0, 8'd0));
    add_row(mk_cmd(CMD_CANCEL, 3'd3, 16'd0, 8'd1, 8'd0));
    add_row(mk_cmd(CMD_CANCEL, 3'd6, 16'd0, 8'd99, 8'd0));
    add_row(mk_cmd(CMD_DEQ, 3'd3, 16'd0, 8'd0, 8'd0));
    add_row(mk_cmd(CMD_CANCEL, 3'd0, 16'hFFFF, 8'hFF, 8'hFF));
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].cmd);
      if (directed_rows[i].has_exp) pending_results[$] = directed_rows[i].exp;
    end

    // Random part in three idling phases, with one long receiver stall.
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 3) begin
        send_idle_pct = 63;
        recv_idle_pct = 25;
      end
      if (i == 2 * NumRandom / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == 40) begin
        hold_recv = 1'b1;
        fork
          begin
            repeat (400) @(posedge clk);
            hold_recv = 1'b0;
          end
        join_none
      end
      d = random_cmd();
      send_item(d);
    end
    in_valid <= 1'b0;
    drain_results();
    repeat (200) @(posedge clk);

    $display("Sent %0d commands (%0d cancels), checked %0d results.",
             items_sent, cancels_sent, results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("Mismatches: %0d, results still owed: %0d", mismatches,
               pending_results.size());
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
